/* sv/five_bit_to_byte_packer_defines.svh */
// Assertion macros for the five-bit to byte packer.
`ifndef FIVE_BIT_TO_BYTE_PACKER_DEFINES_SVH
`define FIVE_BIT_TO_BYTE_PACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FBP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fbp_pkg.sv */
// Shared types and constants of the five-bit to byte packer.
`default_nettype none

package fbp_pkg;

  localparam int VALUE_BITS = 5;
  localparam int BYTE_BITS  = 8;
  localparam int CNT_W      = 3;
  localparam int BITS_W     = BYTE_BITS + VALUE_BITS;
  localparam int TOT_W      = 4;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [VALUE_BITS-1:0] pixel_value;
    logic                  last_value;
  } fbp_in_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] packed_byte;
    logic                 last_byte;
  } fbp_out_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } fbp_op_t;

  typedef struct packed {
    fbp_op_t               op;
    logic [VALUE_BITS-1:0] pix;
  } fbp_cmd_t;

  typedef struct packed {
    logic full;
    logic vld;
  } fbp_qstat_t;

  typedef struct packed {
    logic sec_vld;
    logic out_vld;
  } fbp_bstat_t;

endpackage

`default_nettype wire

/* sv/fbp_front.sv */
// Front stage: accept input items and classify them into pack commands.
`default_nettype none

module fbp_front import fbp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire fbp_in_t    in_data,
  output logic            push,
  output fbp_cmd_t        push_cmd,
  input  wire fbp_qstat_t qstat
);

  logic     vld_r, vld_nxt;
  fbp_cmd_t cmd_r, cmd_nxt;
  logic     accept;

  assign in_stall = vld_r && qstat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = vld_r && !qstat.full;
  assign push_cmd = cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    cmd_nxt = cmd_r;
    if (accept) begin
      vld_nxt     = 1'b1;
      cmd_nxt.pix = in_data.pixel_value;
      cmd_nxt.op  = in_data.last_value ? OP_FLUSH : OP_PIXEL;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

/* sv/fbp_queue.sv */
// Short command queue between the front and back stages.
`default_nettype none

module fbp_queue import fbp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire fbp_cmd_t push_cmd,
  input  wire logic     pop,
  output fbp_cmd_t      pop_cmd,
  output fbp_qstat_t    qstat
);

  fbp_cmd_t          mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_r, wr_nxt;
  logic [Q_AW-1:0]   rd_r, rd_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  assign qstat.full = (cnt_r == Q_CW'(Q_DEPTH));
  assign qstat.vld  = (cnt_r != '0);
  assign pop_cmd    = mem[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + Q_CW'(push) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* sv/fbp_back.sv */
// Back stage: bit accumulator, byte assembly and output register.
`default_nettype none

module fbp_back import fbp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_vld,
  input  wire fbp_cmd_t   q_cmd,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output fbp_out_t        out_data,
  output fbp_bstat_t      bstat
);

  logic [BYTE_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_vld_r, out_vld_nxt;
  fbp_out_t             out_r, out_nxt;
  logic                 sec_vld_r, sec_vld_nxt;
  fbp_out_t             sec_r, sec_nxt;

  logic [BITS_W-1:0]    bits, rem_bits, first_w, flush_w;
  logic [TOT_W-1:0]     total, rem_w, pad;
  logic [CNT_W-1:0]     rem;
  logic                 full;
  logic                 emit0, emit1;
  fbp_out_t             res0, res1;
  logic [BYTE_BITS-1:0] st_acc;
  logic [CNT_W-1:0]     st_cnt;
  logic                 out_free;

  // Byte assembly for the command at the queue head.
  always_comb begin
    bits     = {acc_r, q_cmd.pix};
    total    = TOT_W'(cnt_r) + TOT_W'(VALUE_BITS);
    full     = (total >= TOT_W'(BYTE_BITS));
    rem_w    = full ? total - TOT_W'(BYTE_BITS) : total;
    rem      = rem_w[CNT_W-1:0];
    first_w  = bits >> rem;
    rem_bits = bits & ~({BITS_W{1'b1}} << rem);
    pad      = TOT_W'(BYTE_BITS) - TOT_W'(rem);
    flush_w  = rem_bits << pad;

    emit0  = 1'b0;
    emit1  = 1'b0;
    res0   = '{packed_byte: first_w[BYTE_BITS-1:0], last_byte: 1'b0};
    res1   = '{packed_byte: flush_w[BYTE_BITS-1:0], last_byte: 1'b1};
    st_acc = rem_bits[BYTE_BITS-1:0];
    st_cnt = rem;

    unique case (q_cmd.op)
      OP_PIXEL: begin
        emit0 = full;
      end
      OP_FLUSH: begin
        st_acc = '0;
        st_cnt = '0;
        if (full && (rem != '0)) begin
          emit0 = 1'b1;
          emit1 = 1'b1;
        end else if (full) begin
          emit0          = 1'b1;
          res0.last_byte = 1'b1;
        end else if (rem != '0) begin
          emit0 = 1'b1;
          res0  = res1;
        end
      end
      default: begin
        emit0 = 1'b0;
      end
    endcase
  end

  // Output register and spare slot for the second byte of a flush.
  always_comb begin
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    sec_vld_nxt = sec_vld_r;
    sec_nxt     = sec_r;
    pop         = 1'b0;
    out_free    = !out_vld_r || !out_stall;
    if (sec_vld_r) begin
      if (out_free) begin
        out_nxt     = sec_r;
        out_vld_nxt = 1'b1;
        sec_vld_nxt = 1'b0;
      end
    end else if (out_free) begin
      out_vld_nxt = 1'b0;
      if (q_vld) begin
        pop     = 1'b1;
        acc_nxt = st_acc;
        cnt_nxt = st_cnt;
        if (emit0) begin
          out_nxt     = res0;
          out_vld_nxt = 1'b1;
        end
        if (emit1) begin
          sec_nxt     = res1;
          sec_vld_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      sec_vld_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
      sec_vld_r <= sec_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sec_r <= sec_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_data      = out_r;
  assign bstat.sec_vld = sec_vld_r;
  assign bstat.out_vld = out_vld_r;

endmodule

`default_nettype wire

/* sv/five_bit_to_byte_packer.sv */
// Top level: packs five-bit pixel values MSB first into a byte stream.
// An item's first byte passes the front register, queue and output register.
// Throughput: one item per cycle while the queue is not full; a flush that yields two
// bytes holds the back stage for the second byte, which the four-entry queue absorbs.
// Rate is set by the single output register draining one byte per cycle when not stalled.
// Reset (rst_n low, synchronous) empties the queue and clears accumulator and count.
`default_nettype none

`include "five_bit_to_byte_packer_defines.svh"

module five_bit_to_byte_packer import fbp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire fbp_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output fbp_out_t     out_data
);

  // Front to queue: one classified command per push.
  logic       q_push;
  fbp_cmd_t   q_push_cmd;
  // Queue to back: head command, popped when the back stage takes it.
  logic       q_pop;
  fbp_cmd_t   q_pop_cmd;
  fbp_qstat_t qstat;
  fbp_bstat_t bstat;

  // Register the item and tag it as a plain pixel or a flushing pixel.
  fbp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .qstat    (qstat)
  );

  // Decouple the two sides so an output stall does not block input right away.
  fbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .qstat    (qstat)
  );

  // Accumulate bits, emit full bytes and pad the final byte on a flush.
  fbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (qstat.vld),
    .q_cmd     (q_pop_cmd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .bstat     (bstat)
  );

  // Never write into a full queue.
  `FBP_ASSERT_IMPL(a_push_not_full, q_push, !qstat.full, "push into full queue")
  // Pop only a queue that holds a command.
  `FBP_ASSERT_IMPL(a_pop_needs_data, q_pop, qstat.vld, "pop from empty queue")
  // A waiting second byte always sits behind a valid output byte.
  `FBP_ASSERT_IMPL(a_sec_behind_out, bstat.sec_vld, bstat.out_vld, "spare byte without output")
  // While a second byte waits, the back stage takes no command.
  `FBP_ASSERT_IMPL(a_no_pop_on_sec, bstat.sec_vld, !q_pop, "pop while spare byte pending")

endmodule

`default_nettype wire

/* sim/five_bit_to_byte_packer_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the five-bit to byte packer: directed table, then random images.

module five_bit_to_byte_packer_test;
  import fbp_pkg::*;

  // Cycles with no item moving on either channel before the run is called hung.
  localparam int IDLE_LIMIT   = 5000;
  // Cycles to watch for stray bytes once every expected byte has arrived.
  localparam int DRAIN_CYCLES = 16;
  // Random items queued per idling phase.
  localparam int PHASE_ITEMS  = 275;
  localparam int PHASES       = 4;
  localparam int PIX_MAX      = (1 << VALUE_BITS) - 1;

  // Idling per phase, in percent: none, sender only, receiver only, both.
  localparam int SEND_IDLE [PHASES] = '{0, 53, 0, 19};
  localparam int RECV_IDLE [PHASES] = '{0, 0, 53, 19};

  // One row of the directed table. With typed set, the row's result is written
  // out by hand: has_byte says whether it yields a byte, exp_byte which one.
  // Rows without typed are scored by the packing predictor.
  typedef struct packed {
    logic [VALUE_BITS-1:0] pix;
    logic                  last;
    logic                  typed;
    logic                  has_byte;
    logic [BYTE_BITS-1:0]  exp_byte;
    logic                  exp_last;
  } pixel_row_t;

  // One item waiting to be sent, with its hand-written result if any.
  typedef struct packed {
    fbp_in_t  item;
    logic     typed;
    logic     has_byte;
    fbp_out_t typed_out;
  } pixel_job_t;

  localparam int DIR_ROWS = 20;
  localparam pixel_row_t DIRECTED [DIR_ROWS] = '{
    // Lone flushes from reset: five bits padded to the top of one byte.
    '{5'd31, 1'b1, 1'b1, 1'b1, 8'hF8, 1'b1},
    '{5'd0,  1'b1, 1'b1, 1'b1, 8'h00, 1'b1},
    // Two all-ones pixels fill one byte of ones and leave two bits pending.
    '{5'd31, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
    '{5'd31, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b0},
    // Bring the count to seven, then flush: full byte first, padded byte last.
    '{5'd0,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{5'd31, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
    // Eight pixels make exactly five bytes: the flush adds no extra byte.
    '{5'd16, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
    '{5'd8,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{5'd4,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{5'd2,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{5'd1,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{5'd21, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{5'd10, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{5'd21, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
    // All-zero image of two pixels: one full byte and one padded byte.
    '{5'd0,  1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
    '{5'd0,  1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
    // All-ones image of four pixels.
    '{5'd31, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
    '{5'd31, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b0},
    '{5'd31, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{5'd31, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  fbp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fbp_out_t out_data;

  // Predictor copy of the packer state.
  logic [BYTE_BITS-1:0] pend_bits  = '0;
  logic [CNT_W-1:0]     pend_count = '0;

  pixel_job_t pixel_queue [$];     // items still to send
  pixel_job_t cur_job      = '0;   // item now on the input channel
  fbp_out_t   packed_now [$];      // bytes the last predicted item yields
  fbp_out_t   expected_bytes [$];  // bytes owed by the block, oldest first

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  five_bit_to_byte_packer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append one pixel to the pending bits and collect the bytes it completes in
  // packed_now. A flush pads the remainder to the top of a last byte, or marks
  // the byte just completed as last when nothing remains, then clears state.
  function automatic void pack_pixel(input fbp_in_t item);
    logic [BYTE_BITS-1:0] keep_mask;
    logic [BITS_W-1:0]    bits;
    logic [BITS_W-1:0]    shifted;
    fbp_out_t             one_byte;
    int                   total;
    packed_now.delete();
    keep_mask = (BYTE_BITS'(1) << pend_count) - BYTE_BITS'(1);
    bits      = {pend_bits & keep_mask, item.pixel_value};
    total     = int'(pend_count) + VALUE_BITS;
    if (total >= BYTE_BITS) begin
      total                -= BYTE_BITS;
      shifted               = bits >> total;
      one_byte.packed_byte  = shifted[BYTE_BITS-1:0];
      one_byte.last_byte    = 1'b0;
      packed_now.push_back(one_byte);
      bits &= (BITS_W'(1) << total) - BITS_W'(1);
    end
    if (item.last_value) begin
      if (total > 0) begin
        shifted              = bits << (BYTE_BITS - total);
        one_byte.packed_byte = shifted[BYTE_BITS-1:0];
        one_byte.last_byte   = 1'b1;
        packed_now.push_back(one_byte);
      end else if (packed_now.size() != 0) begin
        packed_now[0].last_byte = 1'b1;
      end
      pend_bits  = '0;
      pend_count = '0;
    end else begin
      pend_bits  = bits[BYTE_BITS-1:0];
      pend_count = total[CNT_W-1:0];
    end
  endfunction

  // Sender: score the item that moves at this edge, then present the next one
  // or idle. Hold the payload while the block stalls it.
  always @(posedge clk) begin : pixel_sender
    pixel_job_t next_job;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pack_pixel(in_data);
        if (cur_job.typed) begin
          if (cur_job.has_byte) expected_bytes.push_back(cur_job.typed_out);
        end else begin
          foreach (packed_now[i]) expected_bytes.push_back(packed_now[i]);
        end
      end
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_job = pixel_queue.pop_front();
          cur_job  <= next_job;
          in_data  <= next_job.item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each accepted byte with the oldest one owed, then pick
  // the stall for the next edge.
  always @(posedge clk) begin : byte_checker
    fbp_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("byte %h with last_byte %b arrived with none owed",
                 out_data.packed_byte, out_data.last_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.packed_byte !== want.packed_byte) begin
            $error("packed_byte: expected %h, got %h", want.packed_byte, out_data.packed_byte);
            fail_count++;
          end
          if (out_data.last_byte !== want.last_byte) begin
            $error("last_byte: expected %b, got %b", want.last_byte, out_data.last_byte);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: drop the run once nothing has moved for too long.
  always @(posedge clk) begin : hang_watch
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("five_bit_to_byte_packer test failed");
      $finish;
    end
  end

  initial begin : sequencer
    pixel_job_t job;
    int         queued;
    int         len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table first; it runs in the phase with no idling.
    for (int r = 0; r < DIR_ROWS; r++) begin
      job.item.pixel_value   = DIRECTED[r].pix;
      job.item.last_value    = DIRECTED[r].last;
      job.typed              = DIRECTED[r].typed;
      job.has_byte           = DIRECTED[r].has_byte;
      job.typed_out.packed_byte = DIRECTED[r].exp_byte;
      job.typed_out.last_byte   = DIRECTED[r].exp_last;
      pixel_queue.push_back(job);
    end

    // Random images: mostly short, now and then long, each closed by a flush.
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = SEND_IDLE[p];
      recv_idle_pct = RECV_IDLE[p];
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(7))
            0:       job.item.pixel_value = '0;
            1:       job.item.pixel_value = VALUE_BITS'(PIX_MAX);
            default: job.item.pixel_value = VALUE_BITS'($urandom_range(PIX_MAX));
          endcase
          job.item.last_value = (k == len - 1);
          job.typed     = 1'b0;
          job.has_byte  = 1'b0;
          job.typed_out = '0;
          pixel_queue.push_back(job);
        end
        queued += len;
      end
      // Advance to the next phase once every queued item has been taken.
      while (pixel_queue.size() != 0 || in_valid) @(posedge clk);
    end

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("five_bit_to_byte_packer test passed");
    end else begin
      $display("five_bit_to_byte_packer test failed");
    end
    $finish;
  end

endmodule
